[rtl/imc_pkg.sv]
// Package for the image mask convolution core: geometry constants and types.
// No dependencies; imported by every module of the core.
package imc_pkg;

  localparam int MaxKernel  = 5;
  localparam int MaxWidth   = 1024;
  localparam int PixelBits  = 8;
  localparam int CoeffBits  = 12;
  localparam int HeightLim  = 4096;
  localparam int LineRows   = MaxKernel - 1;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowBits    = 12;
  localparam int WidthBits  = 11;
  localparam int HeightBits = 13;
  localparam int KsizeBits  = 3;
  localparam int RowWBits   = 60;
  localparam int SumBits    = 25;
  localparam int ProdBits   = PixelBits + CoeffBits + 1;
  localparam int AccBits    = ProdBits + 5;
  localparam int CfgIdxBits = 3;
  localparam int TdataBits  = 48;

  typedef enum logic [CfgIdxBits-1:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegKsize  = 3'd2,
    RegCoeff0 = 3'd3,
    RegCoeff1 = 3'd4,
    RegCoeff2 = 3'd5,
    RegCoeff3 = 3'd6,
    RegCoeff4 = 3'd7
  } cfg_reg_e;

  typedef logic [PixelBits-1:0] pixel_t;
  typedef pixel_t [LineRows-1:0] line_col_t;
  typedef pixel_t [MaxKernel-1:0][MaxKernel-1:0] window_t;
  typedef logic signed [CoeffBits-1:0] coeff_t;
  typedef coeff_t [MaxKernel-1:0][MaxKernel-1:0] mask_t;

  typedef struct packed {
    logic                  valid;
    logic [ColBits-1:0]    pos_x;
    logic [RowBits-1:0]    pos_y;
    logic                  frame_last;
    logic [KsizeBits-1:0]  ksize;
  } tag_t;

endpackage

[rtl/imc_line_buffer.sv]
// Line store of the image mask convolution core: one synchronous memory, one row a column.
// Depends on imc_pkg.
module imc_line_buffer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [imc_pkg::ColBits-1:0] addr_i,
  input  imc_pkg::pixel_t             pixel_i,
  output imc_pkg::line_col_t          col_o
);
  import imc_pkg::*;

  line_col_t          mem [MaxWidth];
  line_col_t          rd_q;
  line_col_t          fwd_col_q;
  line_col_t          cur;
  line_col_t          wr_d;
  logic [ColBits:0]   fill_q;
  logic [ColBits-1:0] addr_q;
  pixel_t             px_q;
  logic               hit_q;
  logic               fwd_q;
  logic               wr_pend_q;

  // Read at the accepting edge, write the shifted column back in the following cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) rd_q <= mem[addr_i];
    if (wr_pend_q) mem[addr_q] <= wr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      addr_q    <= '0;
      px_q      <= '0;
      hit_q     <= 1'b0;
      fwd_q     <= 1'b0;
      fwd_col_q <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= en_i;
      if (en_i) begin
        addr_q    <= addr_i;
        px_q      <= pixel_i;
        hit_q     <= {1'b0, addr_i} < fill_q;
        fwd_q     <= wr_pend_q && (addr_q == addr_i);
        fwd_col_q <= wr_d;
        if ({1'b0, addr_i} >= fill_q) fill_q <= {1'b0, addr_i} + (ColBits+1)'(1);
      end
    end
  end

  // Columns at or beyond the fill mark were never written and read as zero.
  always_comb begin
    if (fwd_q) cur = fwd_col_q;
    else if (hit_q) cur = rd_q;
    else cur = '0;
    for (int r = 0; r < LineRows - 1; r++) wr_d[r] = cur[r+1];
    wr_d[LineRows-1] = px_q;
  end

  assign col_o = cur;

endmodule

[rtl/imc_mac_tree.sv]
// Multiply and adder tree of the image mask convolution core, with saturation.
// Depends on imc_pkg.
module imc_mac_tree (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  imc_pkg::window_t            win_i,
  input  imc_pkg::mask_t              mask_i,
  input  imc_pkg::tag_t               tag_i,
  output imc_pkg::tag_t               tag_o,
  output logic signed [imc_pkg::SumBits-1:0] sum_o
);
  import imc_pkg::*;

  logic signed [ProdBits-1:0] prod_q [MaxKernel][MaxKernel];
  logic signed [AccBits-1:0]  row_q [MaxKernel];
  logic signed [AccBits-1:0]  tot_d;
  tag_t tag1_q, tag2_q;
  logic [KsizeBits-1:0] off;

  assign off = KsizeBits'(MaxKernel) - tag_i.ksize;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < MaxKernel; r++) begin
        for (int c = 0; c < MaxKernel; c++) begin
          if (r >= 32'(off) && c >= 32'(off))
            prod_q[r][c] <= $signed({1'b0, win_i[r][c]}) *
                            $signed(mask_i[r - 32'(off)][c - 32'(off)]);
          else
            prod_q[r][c] <= '0;
        end
      end
    end
  end

  logic signed [AccBits-1:0] rs [MaxKernel];
  always_comb begin
    for (int r = 0; r < MaxKernel; r++) begin
      rs[r] = '0;
      for (int c = 0; c < MaxKernel; c++) rs[r] = rs[r] + AccBits'(prod_q[r][c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) for (int r = 0; r < MaxKernel; r++) row_q[r] <= rs[r];
  end

  always_comb begin
    tot_d = '0;
    for (int r = 0; r < MaxKernel; r++) tot_d = tot_d + row_q[r];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  localparam logic signed [AccBits-1:0] Hi = AccBits'((1 << (SumBits-1)) - 1);
  localparam logic signed [AccBits-1:0] Lo = -AccBits'(1 << (SumBits-1));

  assign tag_o = tag2_q;
  assign sum_o = (tot_d > Hi) ? SumBits'(Hi) : (tot_d < Lo) ? SumBits'(Lo) : SumBits'(tot_d);

endmodule

[rtl/image_mask_convolution_core.sv]
// Top level of the image mask convolution core: config registers, counters, window, output.
// Depends on imc_pkg, imc_line_buffer and imc_mac_tree.
//
// One pixel is taken every clock cycle while the output register is empty or being taken;
// a waiting result stalls the whole pipeline and the input with it. The line store is a
// single memory read at the accepting edge and written back in the following cycle, with the new
// column forwarded when the same column comes straight back; columns not written since reset
// read as zero through a fill mark, so no clearing pass is needed. A result passes the stage 1,
// window, product, row-sum and output registers, all of which hold while the output stalls.
module image_mask_convolution_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // pos_x, pos_y, filtered, zero fill
  output logic        m_axis_tlast,   // frame_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [59:0] cfg_data_i
);
  import imc_pkg::*;

  logic [WidthBits-1:0]  width_q;
  logic [HeightBits-1:0] height_q;
  logic [KsizeBits-1:0]  ksize_q;
  logic [RowWBits-1:0]   coeff_q [MaxKernel];
  mask_t mask;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 13'd480;
      ksize_q  <= 3'd3;
      for (int i = 0; i < MaxKernel; i++) coeff_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegWidth:  width_q  <= cfg_data_i[WidthBits-1:0];
        RegHeight: height_q <= cfg_data_i[HeightBits-1:0];
        RegKsize:  ksize_q  <= cfg_data_i[KsizeBits-1:0];
        RegCoeff0: coeff_q[0] <= cfg_data_i;
        RegCoeff1: coeff_q[1] <= cfg_data_i;
        RegCoeff2: coeff_q[2] <= cfg_data_i;
        RegCoeff3: coeff_q[3] <= cfg_data_i;
        RegCoeff4: coeff_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb
    for (int r = 0; r < MaxKernel; r++)
      for (int c = 0; c < MaxKernel; c++)
        mask[r][c] = coeff_q[r][c*CoeffBits +: CoeffBits];

  logic adv;
  logic out_v_q;
  assign adv = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;
  logic acc;
  assign acc = s_axis_tvalid && adv;

  logic [WidthBits-1:0]  w;
  logic [HeightBits-1:0] h;
  logic [ColBits-1:0]    x_q;
  logic [RowBits-1:0]    y_q;
  always_comb begin
    w = (width_q == '0) ? 11'd1 : (width_q > 11'(MaxWidth)) ? 11'(MaxWidth) : width_q;
    h = (height_q == '0) ? 13'd1 : (height_q > 13'(HeightLim)) ? 13'(HeightLim) : height_q;
  end

  // Stage 1: registered pixel and position while the line store read is out.
  logic            s1_v_q;
  pixel_t          s1_px_q;
  tag_t            s1_tag_q;
  tag_t            tag_d;
  logic [2:0]      rad;
  assign rad = ksize_q >> 1;

  always_comb begin
    tag_d.valid = ksize_q[0] && ksize_q <= 3'(MaxKernel) &&
                  {1'b0, x_q} < w && {1'b0, y_q} < h &&
                  ({1'b0, x_q} + 11'd1 >= 11'(ksize_q)) &&
                  ({1'b0, y_q} + 13'd1 >= 13'(ksize_q));
    tag_d.pos_x = x_q - ColBits'(rad);
    tag_d.pos_y = y_q - RowBits'(rad);
    tag_d.frame_last = ({1'b0, x_q} == w - 11'd1) && ({1'b0, y_q} == h - 13'd1);
    tag_d.ksize = ksize_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (acc) begin
      if ({1'b0, x_q} + 11'd1 >= w) begin
        x_q <= '0;
        y_q <= ({1'b0, y_q} + 13'd1 >= h) ? '0 : y_q + 12'd1;
      end else begin
        x_q <= x_q + 10'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_tag_q <= '0;
    end else if (adv) begin
      s1_v_q   <= acc;
      s1_tag_q <= acc ? tag_d : '0;
    end
  end
  always_ff @(posedge clk_i) if (acc) s1_px_q <= s_axis_tdata;

  line_col_t lcol;
  imc_line_buffer u_lb (
    .clk_i, .rst_ni, .en_i(acc), .addr_i(x_q), .pixel_i(s_axis_tdata), .col_o(lcol)
  );

  window_t win_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) win_q <= '0;
    else if (adv && s1_v_q) begin
      for (int r = 0; r < MaxKernel; r++)
        for (int c = 0; c < MaxKernel - 1; c++) win_q[r][c] <= win_q[r][c+1];
      for (int r = 0; r < LineRows; r++) win_q[r][MaxKernel-1] <= lcol[r];
      win_q[MaxKernel-1][MaxKernel-1] <= s1_px_q;
    end
  end

  tag_t s2_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_tag_q <= '0;
    else if (adv) s2_tag_q <= s1_tag_q;
  end

  tag_t mt;
  logic signed [SumBits-1:0] sum;
  imc_mac_tree u_mac (
    .clk_i, .rst_ni, .en_i(adv), .win_i(win_q), .mask_i(mask),
    .tag_i(s2_tag_q), .tag_o(mt), .sum_o(sum)
  );

  logic [TdataBits-1:0] od_q;
  logic                 ol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= mt.valid;
  end
  always_ff @(posedge clk_i)
    if (adv) begin
      od_q <= {1'b0, sum, mt.pos_y, mt.pos_x};
      ol_q <= mt.frame_last;
    end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

`ifndef ASSERT_OFF
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept while stalled");
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, x_q} < 11'(MaxWidth)) else $error("column out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s1_tag_q)) else $error("pipeline moved while stalled");
`endif

endmodule

[dv/image_mask_convolution_core_tb.sv]
// Testbench for image_mask_convolution_core: streams pixel frames, predicts every filtered
// sum with an in-bench correlation model and checks each output transaction in order.
// Depends on imc_pkg and the core RTL.
module image_mask_convolution_core_tb;
  import imc_pkg::*;

  typedef struct packed {
    logic [9:0]  pos_x;
    logic [11:0] pos_y;
    logic [24:0] filtered;
    logic        frame_last;
  } conv_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [59:0] cfg_data_i = '0;

  image_mask_convolution_core DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  lines_q [LineRows][MaxWidth];
  logic [7:0]  win_q [MaxKernel][MaxKernel];
  int unsigned col_q, row_q;
  int unsigned width_q, height_q, ksize_q;
  logic [59:0] coeffs_q [MaxKernel];

  conv_result_t sums_pending[$];
  int          errors = 0;
  longint      cycles = 0;
  int          rx_idle_pct = 9;
  int          tx_idle_pct = 9;
  int          rx_hold = 0;
  int          items_sent = 0;

  function automatic longint coeff_of(int unsigned r, int unsigned c);
    logic signed [11:0] v;
    v = coeffs_q[r][c*12 +: 12];
    return longint'(v);
  endfunction

  task automatic predict_pixel(input logic [7:0] px);
    int unsigned w, h, x, y, rad, off;
    logic [7:0]  column [MaxKernel];
    longint      acc;
    conv_result_t res;
    w = (width_q == 0) ? 1 : (width_q > MaxWidth ? MaxWidth : width_q);
    h = (height_q == 0) ? 1 : (height_q > HeightLim ? HeightLim : height_q);
    x = (col_q >= MaxWidth) ? MaxWidth - 1 : col_q;
    y = row_q;
    for (int r = 0; r < LineRows; r++) column[r] = lines_q[r][x];
    column[MaxKernel-1] = px;
    for (int r = 0; r < MaxKernel; r++) begin
      for (int c = 0; c < MaxKernel - 1; c++) win_q[r][c] = win_q[r][c+1];
      win_q[r][MaxKernel-1] = column[r];
    end
    for (int r = 0; r < LineRows - 1; r++) lines_q[r][x] = lines_q[r+1][x];
    lines_q[LineRows-1][x] = px;
    if (ksize_q != 0 && ksize_q[0] && ksize_q <= MaxKernel && x < w && y < h &&
        x + 1 >= ksize_q && y + 1 >= ksize_q) begin
      rad = ksize_q / 2;
      off = MaxKernel - ksize_q;
      acc = 0;
      for (int r = 0; r < ksize_q; r++)
        for (int c = 0; c < ksize_q; c++)
          acc += longint'(win_q[off+r][off+c]) * coeff_of(r, c);
      if (acc > 64'sd16777215) acc = 16777215;
      if (acc < -64'sd16777216) acc = -16777216;
      res.pos_x = 10'(x - rad);
      res.pos_y = 12'(y - rad);
      res.filtered = 25'(acc);
      res.frame_last = (x == w - 1 && y == h - 1);
      sums_pending.push_back(res);
    end
    if (x + 1 >= w) begin
      col_q = 0;
      row_q = (y + 1 >= h) ? 0 : ((y + 1) & 12'hfff);
    end else begin
      col_q = (x + 1) & 10'h3ff;
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [59:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegWidth:  width_q = value[10:0];
      RegHeight: height_q = value[12:0];
      RegKsize:  ksize_q = value[2:0];
      default:   coeffs_q[idx - RegCoeff0] = value;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] px);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(px);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (sums_pending.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_geometry(input int w, input int h, input int k);
    drain();
    write_reg(RegWidth, 60'(w));
    write_reg(RegHeight, 60'(h));
    write_reg(RegKsize, 60'(k));
  endtask

  function automatic logic [59:0] random_mask_row();
    return 60'({$urandom, $urandom});
  endfunction

  task automatic send_frame(input int n, input bit extreme);
    for (int i = 0; i < n; i++)
      send_pixel(extreme ? (($urandom_range(1)) ? 8'hff : 8'h00) : 8'($urandom));
  endtask

  task automatic test_directed;
    // 3x3 frame, kernel 3, extreme coefficients for the largest positive sum
    set_geometry(3, 3, 3);
    for (int r = 0; r < MaxKernel; r++)
      write_reg(cfg_reg_e'(RegCoeff0 + r), {5{12'h7ff}});
    for (int i = 0; i < 9; i++) send_pixel(8'hff);
    drain();
    for (int r = 0; r < MaxKernel; r++)
      write_reg(cfg_reg_e'(RegCoeff0 + r), {5{12'h800}});
    set_geometry(5, 1, 1);
    send_pixel(8'hff); send_pixel(8'h00); send_pixel(8'h80); send_pixel(8'h7f);
    send_pixel(8'h55);
    set_geometry(0, 0, 1);
    send_pixel(8'haa);
    set_geometry(2, 2, 2);
    send_frame(4, 0);
    set_geometry(2, 2, 0);
    send_frame(4, 0);
  endtask

  task automatic test_midframe_change;
    set_geometry(6, 6, 3);
    send_frame(20, 0);
    set_geometry(4, 3, 3);
    send_frame(24, 0);
    set_geometry(1024, 1, 5);
    send_frame(12, 0);
    set_geometry(2047, 8191, 7);
    send_frame(6, 0);
  endtask

  task automatic test_random_frames;
    int w, h, k, rem;
    while (items_sent < 1100) begin
      w = ($urandom_range(15) == 0) ? $urandom_range(200, 1024) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      k = ($urandom_range(9) == 0) ? $urandom_range(7) : 2 * $urandom_range(2) + 1;
      if (w * h > 400) h = 1 + 400 / w;
      rem = 1100 - items_sent;
      set_geometry(w, h, k);
      for (int r = 0; r < MaxKernel; r++) write_reg(cfg_reg_e'(RegCoeff0 + r), random_mask_row());
      tx_idle_pct = (items_sent > 600 && items_sent < 800) ? 0 : 9;
      rx_idle_pct = tx_idle_pct;
      send_frame((w * h > rem) ? rem : w * h, $urandom_range(4) == 0);
    end
    tx_idle_pct = 9;
    rx_idle_pct = 9;
  endtask

  task automatic test_backpressure;
    set_geometry(8, 8, 3);
    fork
      rx_hold = 120;
      send_frame(64, 0);
    join
  endtask

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    conv_result_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[9:0], m_axis_tdata[21:10], m_axis_tdata[46:22], m_axis_tlast};
      if (sums_pending.size() == 0) begin
        $display("%0t: expected no result, actual x=%0d y=%0d sum=%0d", $time, got.pos_x,
                 got.pos_y, $signed(got.filtered));
        errors++;
      end else begin
        want = sums_pending.pop_front();
        if (got.pos_x !== want.pos_x)
          $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
        if (got.pos_y !== want.pos_y)
          $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
        if (got.filtered !== want.filtered)
          $display("%0t: filtered expected %0d actual %0d", $time, $signed(want.filtered),
                   $signed(got.filtered));
        if (got.frame_last !== want.frame_last)
          $display("%0t: frame_last expected %0b actual %0b", $time, want.frame_last,
                   got.frame_last);
        if (got !== want) errors++;
      end
    end
    if (cycles > 400000) begin
      $display("** image_mask_convolution_core: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < LineRows; r++)
      for (int c = 0; c < MaxWidth; c++) lines_q[r][c] = '0;
    for (int r = 0; r < MaxKernel; r++) begin
      coeffs_q[r] = '0;
      for (int c = 0; c < MaxKernel; c++) win_q[r][c] = '0;
    end
    col_q = 0; row_q = 0; width_q = 640; height_q = 480; ksize_q = 3;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_midframe_change();
    test_backpressure();
    test_random_frames();
    drain();
    if (errors == 0 && sums_pending.size() == 0) begin
      $display("** image_mask_convolution_core: PASSED **");
    end else begin
      $display("** image_mask_convolution_core: FAILED **");
    end
    $finish;
  end

endmodule
